// File: hdl/wmm_pkg.sv
`default_nettype none
package wmm_pkg;

  localparam int SAMPLE_W = 18;
  localparam int FILL_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IGNORE_NEG = 2'd0,
    REG_MIN_START  = 2'd1,
    REG_MAX_START  = 2'd2
  } cfg_reg_t;

  localparam logic                       IGNORE_NEG_RST = 1'b1;
  localparam logic signed [SAMPLE_W-1:0] MIN_START_RST  = 18'sd6400;
  localparam logic signed [SAMPLE_W-1:0] MAX_START_RST  = 18'sd0;

endpackage
`default_nettype wire

// File: hdl/wmm_channels.sv
`default_nettype none
interface wmm_sample_if;
  import wmm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wmm_result_if;
  import wmm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean;
  logic signed [SAMPLE_W-1:0] running_max;
  logic signed [SAMPLE_W-1:0] running_min;
  logic                       accepted;
  logic [FILL_W-1:0]          fill_count;

  modport source (output valid, output mean, output running_max, output running_min,
                  output accepted, output fill_count, input ready);
  modport sink   (input valid, input mean, input running_max, input running_min,
                  input accepted, input fill_count, output ready);
endinterface
`default_nettype wire

// File: hdl/wmm_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Signed dividend, unsigned
// divisor, truncates toward zero; divisor zero gives zero.
module wmm_divider #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [SUM_W-1:0]             dividend,
  input  wire logic [CNT_W-1:0]                    divisor,
  output logic                                     busy,
  output logic signed [wmm_pkg::SAMPLE_W-1:0]      quotient
);
  import wmm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic              neg;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic [SUM_W-1:0]  quo_signed;

  assign rem_sh     = {rem, quo[SUM_W-1]};
  assign diff       = rem_sh - {1'b0, dsr};
  assign fits       = rem_sh >= {1'b0, dsr};
  assign quo_signed = neg ? -quo : quo;
  assign quotient   = quo_signed[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= (divisor != '0);
      step <= STEP_W'(SUM_W);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= (divisor == '0) ? '0 : (dividend[SUM_W-1] ? -dividend : dividend);
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/window_mean_min_max.sv
// Moving average over the last WINDOW accepted samples, with running min/max from the start values.
// The divider starts in S_START; the result is registered once the divider is done and
// the output is free. One sample in flight: a new one is accepted only after the last
// result is loaded, so the bit-serial divider and downstream stalls hold the flow.
// Reset (synchronous, rst high) clears slot, count and sum and loads the
// extremes from their reset start values; window memory contents stay undefined.
`default_nettype none
module window_mean_min_max #(
  parameter int WINDOW = 60
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  wmm_sample_if.sink                             samples,
  wmm_result_if.source                           results,
  input  wire logic                              cfg_we,
  input  wire logic [wmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wmm_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // Sum stays exact: each sample adds at most SAMPLE_W bits of magnitude.
  localparam int SUM_W  = SAMPLE_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV
  } state_t;

  state_t state;

  // Configuration and running state
  logic                       ignore_neg;
  logic signed [SAMPLE_W-1:0] low_mark;
  logic signed [SAMPLE_W-1:0] high_mark;
  logic [SLOT_W-1:0]          write_slot;
  logic [CNT_W-1:0]           held_count;
  logic signed [SUM_W-1:0]    window_sum;

  // Current request
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic                       cur_take;

  // Window ring: one write port, one registered read port.
  logic signed [SAMPLE_W-1:0] store [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       store_we;

  logic                       in_fire;
  logic                       take_in;
  logic                       full;
  logic                       out_free;
  logic                       res_load;

  logic                       div_start;
  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] div_quot;

  assign samples.ready = (state == S_IDLE);
  assign in_fire   = samples.valid && samples.ready;
  // A negative sample is dropped only with the ignore mode on.
  assign take_in   = !(ignore_neg && samples.sample[SAMPLE_W-1]);
  assign full      = (held_count == CNT_W'(WINDOW));
  assign out_free  = !results.valid || results.ready;
  assign res_load  = (state == S_DIV) && !div_busy && out_free;
  assign store_we  = (state == S_UPDATE) && cur_take;
  assign div_start = (state == S_START);

  // Read of the slot about to be overwritten is issued in idle; its data
  // is used in S_UPDATE, the same cycle the slot is rewritten, so the
  // value used was read before the write to that entry.
  always_ff @(posedge clk) begin
    rd_data <= store[write_slot];
    if (store_we) begin
      store[write_slot] <= cur_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_sample <= samples.sample;
      cur_take   <= take_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ignore_neg    <= IGNORE_NEG_RST;
      low_mark      <= MIN_START_RST;
      high_mark     <= MAX_START_RST;
      write_slot    <= '0;
      held_count    <= '0;
      window_sum    <= '0;
      results.valid <= 1'b0;
    end else begin
      if (res_load) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end

      // Start value writes reload the running extremes, unless an accepted sample sets that extreme in the same cycle.
      if (cfg_we) begin
        case (cfg_index)
          REG_IGNORE_NEG: ignore_neg <= cfg_data[0];
          REG_MIN_START:  low_mark   <= $signed(cfg_data[SAMPLE_W-1:0]);
          REG_MAX_START:  high_mark  <= $signed(cfg_data[SAMPLE_W-1:0]);
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (cur_take) begin
            // Full window: oldest sample leaves the sum as the new one enters.
            window_sum <= window_sum + SUM_W'(cur_sample)
                          - (full ? SUM_W'(rd_data) : SUM_W'(0));
            if (!full) begin
              held_count <= held_count + 1'b1;
            end
            write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            if (cur_sample > high_mark) begin
              high_mark <= cur_sample;
            end
            if (cur_sample < low_mark) begin
              low_mark <= cur_sample;
            end
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          // Result waits here while the divider is busy or the previous one is still held downstream.
          if (res_load) begin
            results.mean        <= div_quot;
            results.running_max <= high_mark;
            results.running_min <= low_mark;
            results.accepted    <= cur_take;
            results.fill_count  <= FILL_W'(held_count);
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  wmm_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum),
    .divisor  (held_count),
    .busy     (div_busy),
    .quotient (div_quot)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(WINDOW))
    else $error("held count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(WINDOW - 1))
    else $error("write slot beyond window");

  a_fire_update: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_UPDATE)
    else $error("accepted request did not reach update");

  a_take_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && cur_take) |=> held_count != '0)
    else $error("accepted sample left window empty");

  a_result_accept: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.accepted) |-> results.fill_count != '0 || WINDOW > 63)
    else $error("accepted result with zero fill");
`endif

endmodule
`default_nettype wire
